[rtl/kspm_pkg.sv]
`default_nettype none

package kspm_pkg;

    // Store geometry
    localparam int DEPTH   = 4096;
    localparam int ADDR_W  = $clog2(DEPTH);
    localparam int COUNT_W = $clog2(DEPTH + 1);

    // Field widths
    localparam int KEY_W   = 31;
    localparam int BYTE_W  = 8;
    localparam int CFG_IDX_W = 2;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_PERM_KEY  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_DIRECTION = 2'd1;

    // Input command codes
    localparam logic CMD_LOAD = 1'b0;
    localparam logic CMD_READ = 1'b1;

    // Request to the key reduction unit
    typedef struct packed {
        logic                 start;
        logic [KEY_W-1:0]     key;
        logic [COUNT_W-1:0]   len;
    } kspm_div_req_t;

    // Answer from the key reduction unit
    typedef struct packed {
        logic                 done;
        logic [ADDR_W-1:0]    rem;
    } kspm_div_rsp_t;

endpackage

`default_nettype wire

[rtl/kspm_ram.sv]
`default_nettype none

module kspm_ram #(
    parameter int WIDTH  = 8,
    parameter int ADDR_W = 12
) (
    input  wire logic              aclk,
    input  wire logic              we,
    input  wire logic [ADDR_W-1:0] waddr,
    input  wire logic [WIDTH-1:0]  wdata,
    input  wire logic [ADDR_W-1:0] raddr,
    output logic      [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [2**ADDR_W];
    logic [WIDTH-1:0] rdata_reg;

    // Write port
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port
    always_ff @(posedge aclk) begin
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

[rtl/kspm_keymod.sv]
`default_nettype none

module kspm_keymod
    import kspm_pkg::*;
(
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire kspm_div_req_t req,
    output kspm_div_rsp_t      rsp
);

    logic                busy_reg,  busy_next;
    logic                done_reg,  done_next;
    logic [4:0]          cnt_reg,   cnt_next;
    logic [KEY_W-1:0]    key_reg,   key_next;
    logic [COUNT_W-1:0]  len_reg,   len_next;
    logic [ADDR_W-1:0]   rem_reg,   rem_next;
    logic [COUNT_W-1:0]  trial;

    // One remainder bit per cycle, most significant key bit first
    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        key_next  = key_reg;
        len_next  = len_reg;
        rem_next  = rem_reg;
        trial     = {rem_reg, key_reg[KEY_W-1]};
        if (req.start) begin
            busy_next = 1'b1;
            cnt_next  = 5'(KEY_W - 1);
            key_next  = req.key;
            len_next  = req.len;
            rem_next  = '0;
        end else if (busy_reg) begin
            if (trial >= len_reg) begin
                rem_next = ADDR_W'(trial - len_reg);
            end else begin
                rem_next = ADDR_W'(trial);
            end
            key_next = {key_reg[KEY_W-2:0], 1'b0};
            if (cnt_reg == '0) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end else begin
                cnt_next = cnt_reg - 5'd1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        key_reg <= key_next;
        len_reg <= len_next;
        rem_reg <= rem_next;
    end

    assign rsp.done = done_reg;
    assign rsp.rem  = rem_reg;

endmodule

`default_nettype wire

[rtl/keyed_swap_permuter.sv]
`default_nettype none

// Keyed swap permuter.
// Input stream s_*: one request per byte. s_tuser is the command (0 load,
// 1 read), s_tdata the byte to load and s_tlast marks the final byte of a set.
// Result stream m_*: one result per read request, none per load. m_tdata is
// the permuted byte, m_tlast marks the final byte of the set and m_tuser
// carries the empty and truncated flags.
// After a read is accepted, the byte store read register and then the output
// register lie before m_tvalid rises; once the result has been taken, s_tready
// rises again, so a new request is not taken before the last result has gone.
// After the final load the block runs the permutation pass and holds s_tready
// low: it reduces the key modulo the set length n (one remainder bit a cycle
// for 31 key bits, then a registered done hands over the remainder), builds
// the jump table with one entry per index, then swaps each byte in turn (jump
// table read, byte store read, two byte store writes).
// Reset clears the set, the flags and both configuration registers; the byte
// store keeps whatever it held. The result sits in one output register; while
// it waits to be taken, s_tready stays low and no further request is taken.

module keyed_swap_permuter
    import kspm_pkg::*;
(
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    // configuration write port
    input  wire logic                 cfg_wr_en,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [KEY_W-1:0]     cfg_wdata,
    // request stream
    input  wire logic                 s_tvalid,
    output logic                      s_tready,
    input  wire logic [7:0]           s_tdata,   // [7:0] data_in
    input  wire logic                 s_tlast,   // last_in
    input  wire logic [0:0]           s_tuser,   // [0] cmd
    // result stream
    output logic                      m_tvalid,
    input  wire logic                 m_tready,
    output logic      [7:0]           m_tdata,   // [7:0] data_out
    output logic                      m_tlast,   // last_out
    output logic      [1:0]           m_tuser    // [0] empty_res, [1] truncated
);

    typedef enum logic [7:0] {
        ST_IDLE   = 8'b0000_0001,
        ST_READ   = 8'b0000_0010,
        ST_DIV    = 8'b0000_0100,
        ST_JUMP   = 8'b0000_1000,
        ST_SW_JRD = 8'b0001_0000,
        ST_SW_BRD = 8'b0010_0000,
        ST_SW_WRI = 8'b0100_0000,
        ST_SW_WRJ = 8'b1000_0000
    } state_t;

    state_t              state_reg,     state_next;
    logic [COUNT_W-1:0]  count_reg,     count_next;
    logic [ADDR_W-1:0]   rp_reg,        rp_next;
    logic                ready_reg,     ready_next;
    logic                ovf_reg,       ovf_next;
    logic [KEY_W-1:0]    key_reg,       key_next;
    logic                dir_reg,       dir_next;
    logic [ADDR_W-1:0]   idx_reg,       idx_next;
    logic [ADDR_W-1:0]   ik_reg,        ik_next;
    logic [ADDR_W-1:0]   j_reg,         j_next;
    logic [ADDR_W-1:0]   sj_reg,        sj_next;
    logic [BYTE_W-1:0]   da_reg,        da_next;
    logic                pend_empty_reg, pend_empty_next;
    logic                pend_last_reg,  pend_last_next;
    logic                pend_trunc_reg, pend_trunc_next;
    logic                m_valid_reg,   m_valid_next;
    logic [BYTE_W-1:0]   m_data_reg,    m_data_next;
    logic                m_last_reg,    m_last_next;
    logic [1:0]          m_user_reg,    m_user_next;

    kspm_div_req_t       div_req;
    kspm_div_rsp_t       div_rsp;

    logic                st_we;
    logic [ADDR_W-1:0]   st_waddr;
    logic [BYTE_W-1:0]   st_wdata;
    logic [ADDR_W-1:0]   st_raddr_a;
    logic [BYTE_W-1:0]   st_rdata_a;
    logic [BYTE_W-1:0]   st_rdata_b;
    logic [ADDR_W-1:0]   jt_rdata;

    logic                accept;
    logic [COUNT_W-1:0]  base_count;
    logic                read_empty;
    logic                read_last;
    logic [COUNT_W-1:0]  n_m1;
    logic [COUNT_W-1:0]  jsum;
    logic [ADDR_W-1:0]   j_new;
    logic [COUNT_W-1:0]  ik_inc;
    logic                swap_done;

    assign s_tready = (state_reg == ST_IDLE) && !m_valid_reg;
    assign accept   = s_tvalid && s_tready;

    // Jump table step: j = (i + key + j) mod n, with i + key kept reduced
    assign n_m1   = count_reg - COUNT_W'(1);
    assign jsum   = {1'b0, ik_reg} + {1'b0, j_reg};
    assign j_new  = (jsum >= count_reg) ? ADDR_W'(jsum - count_reg) : ADDR_W'(jsum);
    assign ik_inc = {1'b0, ik_reg} + COUNT_W'(1);

    assign base_count = ready_reg ? '0 : count_reg;
    assign read_empty = !ready_reg || (count_reg == '0) || ({1'b0, rp_reg} >= count_reg);
    assign read_last  = ({1'b0, rp_reg} + COUNT_W'(1)) == count_reg;
    assign swap_done  = dir_reg ? (idx_reg == '0) : ({1'b0, idx_reg} == n_m1);

    always_comb begin
        state_next      = state_reg;
        count_next      = count_reg;
        rp_next         = rp_reg;
        ready_next      = ready_reg;
        ovf_next        = ovf_reg;
        key_next        = key_reg;
        dir_next        = dir_reg;
        idx_next        = idx_reg;
        ik_next         = ik_reg;
        j_next          = j_reg;
        sj_next         = sj_reg;
        da_next         = da_reg;
        pend_empty_next = pend_empty_reg;
        pend_last_next  = pend_last_reg;
        pend_trunc_next = pend_trunc_reg;
        m_valid_next    = m_valid_reg;
        m_data_next     = m_data_reg;
        m_last_next     = m_last_reg;
        m_user_next     = m_user_reg;
        div_req.start   = 1'b0;
        div_req.key     = key_reg;
        div_req.len     = count_reg;
        st_we           = 1'b0;
        st_waddr        = idx_reg;
        st_wdata        = st_rdata_b;
        st_raddr_a      = rp_reg;

        // Configuration writes
        if (cfg_wr_en) begin
            if (cfg_index == REG_PERM_KEY) begin
                key_next = cfg_wdata;
            end else if (cfg_index == REG_DIRECTION) begin
                dir_next = cfg_wdata[0];
            end
        end

        // Drop the result once taken
        if (m_valid_reg && m_tready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE: begin
                if (accept && s_tuser[0] == CMD_LOAD) begin
                    // Abandon a ready set, then append or flag overflow
                    rp_next  = '0;
                    ovf_next = ready_reg ? 1'b0 : ovf_reg;
                    if (base_count < COUNT_W'(DEPTH)) begin
                        st_we      = 1'b1;
                        st_waddr   = base_count[ADDR_W-1:0];
                        st_wdata   = s_tdata;
                        count_next = base_count + COUNT_W'(1);
                    end else begin
                        count_next = base_count;
                        ovf_next   = 1'b1;
                    end
                    ready_next = 1'b0;
                    if (s_tlast) begin
                        ready_next    = 1'b1;
                        div_req.start = 1'b1;
                        div_req.len   = count_next;
                        state_next    = ST_DIV;
                    end
                end else if (accept) begin
                    // Read: store read issued now at rp_reg
                    pend_empty_next = read_empty;
                    pend_last_next  = !read_empty && read_last;
                    pend_trunc_next = !read_empty && ovf_reg;
                    if (!read_empty) begin
                        if (read_last) begin
                            count_next = '0;
                            rp_next    = '0;
                            ready_next = 1'b0;
                            ovf_next   = 1'b0;
                        end else begin
                            rp_next = rp_reg + ADDR_W'(1);
                        end
                    end
                    state_next = ST_READ;
                end
            end
            ST_READ: begin
                m_valid_next = 1'b1;
                m_data_next  = pend_empty_reg ? '0 : st_rdata_a;
                m_last_next  = pend_last_reg;
                m_user_next  = {pend_trunc_reg, pend_empty_reg};
                state_next   = ST_IDLE;
            end
            ST_DIV: begin
                if (div_rsp.done) begin
                    idx_next   = '0;
                    ik_next    = div_rsp.rem;
                    j_next     = '0;
                    state_next = ST_JUMP;
                end
            end
            ST_JUMP: begin
                // Record j for this index, advance i + key modulo n
                j_next  = j_new;
                ik_next = (ik_inc == count_reg) ? '0 : ADDR_W'(ik_inc);
                if ({1'b0, idx_reg} == n_m1) begin
                    idx_next   = dir_reg ? idx_reg : '0;
                    state_next = ST_SW_JRD;
                end else begin
                    idx_next = idx_reg + ADDR_W'(1);
                end
            end
            ST_SW_JRD: begin
                state_next = ST_SW_BRD;
            end
            ST_SW_BRD: begin
                // Jump entry is here: read both bytes
                st_raddr_a = idx_reg;
                sj_next    = jt_rdata;
                state_next = ST_SW_WRI;
            end
            ST_SW_WRI: begin
                st_we      = 1'b1;
                st_waddr   = idx_reg;
                st_wdata   = st_rdata_b;
                da_next    = st_rdata_a;
                state_next = ST_SW_WRJ;
            end
            ST_SW_WRJ: begin
                st_we    = 1'b1;
                st_waddr = sj_reg;
                st_wdata = da_reg;
                if (swap_done) begin
                    idx_next   = '0;
                    state_next = ST_IDLE;
                end else begin
                    idx_next   = dir_reg ? (idx_reg - ADDR_W'(1)) : (idx_reg + ADDR_W'(1));
                    state_next = ST_SW_JRD;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            count_reg   <= '0;
            rp_reg      <= '0;
            ready_reg   <= 1'b0;
            ovf_reg     <= 1'b0;
            key_reg     <= '0;
            dir_reg     <= 1'b0;
            idx_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            rp_reg      <= rp_next;
            ready_reg   <= ready_next;
            ovf_reg     <= ovf_next;
            key_reg     <= key_next;
            dir_reg     <= dir_next;
            idx_reg     <= idx_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // Payload
    always_ff @(posedge aclk) begin
        ik_reg         <= ik_next;
        j_reg          <= j_next;
        sj_reg         <= sj_next;
        da_reg         <= da_next;
        pend_empty_reg <= pend_empty_next;
        pend_last_reg  <= pend_last_next;
        pend_trunc_reg <= pend_trunc_next;
        m_data_reg     <= m_data_next;
        m_last_reg     <= m_last_next;
        m_user_reg     <= m_user_next;
    end

    // Key reduction modulo the set length
    kspm_keymod u_keymod (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (div_req),
        .rsp     (div_rsp)
    );

    // Byte store: two copies written together give two read ports
    kspm_ram #(.WIDTH(BYTE_W), .ADDR_W(ADDR_W)) u_store_a (
        .aclk  (aclk),
        .we    (st_we),
        .waddr (st_waddr),
        .wdata (st_wdata),
        .raddr (st_raddr_a),
        .rdata (st_rdata_a)
    );

    kspm_ram #(.WIDTH(BYTE_W), .ADDR_W(ADDR_W)) u_store_b (
        .aclk  (aclk),
        .we    (st_we),
        .waddr (st_waddr),
        .wdata (st_wdata),
        .raddr (jt_rdata),
        .rdata (st_rdata_b)
    );

    // Jump table, one entry per index
    kspm_ram #(.WIDTH(ADDR_W), .ADDR_W(ADDR_W)) u_jump (
        .aclk  (aclk),
        .we    (state_reg == ST_JUMP),
        .waddr (idx_reg),
        .wdata (j_new),
        .raddr (idx_reg),
        .rdata (jt_rdata)
    );

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tlast  = m_last_reg;
    assign m_tuser  = m_user_reg;

endmodule

`default_nettype wire

[rtl/kspm_checker.sv]
`default_nettype none

module kspm_checker
    import kspm_pkg::*;
(
    input wire logic       aclk,
    input wire logic       aresetn,
    input wire logic       s_tvalid,
    input wire logic       s_tready,
    input wire logic [0:0] s_tuser,
    input wire logic       m_tvalid,
    input wire logic       m_tready,
    input wire logic [7:0] m_tdata,
    input wire logic       m_tlast,
    input wire logic [1:0] m_tuser
);

    // A stalled result holds
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("stalled result changed");

    // An empty result carries no byte and no flags
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[0] |-> m_tdata == 8'd0 && !m_tlast && !m_tuser[1])
        else $error("empty result carries data");

    // No request is taken while a result waits
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_tready |-> !m_tvalid)
        else $error("ready while result pending");

    // A read request yields a result after the store read and the output register
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && s_tuser[0] == CMD_READ |-> ##2 m_tvalid)
        else $error("read result missing");

endmodule

bind keyed_swap_permuter kspm_checker u_kspm_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .m_tuser  (m_tuser)
);

`default_nettype wire
